/* rtl/core/md5_pkg.sv */
package md5_pkg;

    localparam int LENGTH_COUNTER_BITS_DEFAULT = 64;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [1:0] LAST_WORD_IDX = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_SETUP,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    // Which kind of block the current compression works on.
    typedef enum logic [1:0] {
        PASS_DATA,
        PASS_SPILL,
        PASS_LAST
    } pass_t;

    // Control handed to the round unit each cycle.
    typedef struct packed {
        logic [5:0] round;      // round executed this cycle
        logic [5:0] pre_round;  // round whose a + M + K sum is prepared
    } round_ctrl_t;

    function automatic logic [31:0] md5_round_const(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot_amount(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word used by a round; each group of 16 rounds uses every word once.
    function automatic logic [3:0] md5_msg_index(input logic [5:0] r);
        logic [3:0] rl;
        logic [3:0] g;
        rl = r[3:0];
        unique case (r[5:4])
            2'd0:    g = rl;
            2'd1:    g = 4'({2'b00, rl, 2'b00} + {4'b0000, rl} + 8'd1);
            2'd2:    g = 4'({3'b000, rl, 1'b0} + {4'b0000, rl} + 8'd5);
            default: g = 4'({1'b0, rl, 3'b000} - {4'b0000, rl});
        endcase
        return g;
    endfunction

endpackage

/* rtl/core/md5_round.sv */
// One MD5 step per cycle: the boolean function, rotate and add into b, plus
// the a + M + K sum that the following round will need.
module md5_round
(
    input  md5_pkg::round_ctrl_t ctrl,
    input  logic [31:0]          pre_sum,
    input  logic [31:0]          b,
    input  logic [31:0]          c,
    input  logic [31:0]          d,
    input  logic [31:0]          pre_base,
    input  logic [31:0]          pre_word,
    output logic [31:0]          b_new,
    output logic [31:0]          pre_sum_new
);

    logic [31:0] f;
    logic [31:0] t;
    logic [63:0] t_rot;
    logic [4:0]  s;

    always_comb
    begin
        unique case (ctrl.round[5:4])
            2'd0:    f = d ^ (b & (c ^ d));
            2'd1:    f = c ^ (d & (b ^ c));
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
    end

    assign s           = md5_pkg::md5_rot_amount(ctrl.round);
    assign t           = pre_sum + f;
    assign t_rot       = {t, t} << s;
    assign b_new       = b + t_rot[63:32];
    assign pre_sum_new = pre_base + pre_word + md5_pkg::md5_round_const(ctrl.pre_round);

endmodule

/* rtl/core/md5_hash_engine.sv */
// MD5 hash engine, fed one message byte per input transaction.
// Slave channel: s_tdata carries the byte, s_tuser[0] says whether it holds
// a byte at all, and s_tlast ends the message. Master channel: four
// transactions with the digest words, low word first; m_tuser carries the
// word index and m_tlast marks the fourth word.
// A byte that neither completes a 64-byte block nor ends the message is taken
// and leaves the engine ready for more input. The 64th byte of a block starts a
// compression: a setup step, 64 rounds on the shared round unit (one per
// cycle) and a step to add into the chaining words, during which s_tready
// is low. A last transaction adds a padding step and one compression, or
// two when the length field spills into a second
// block, plus a compression of the just filled block if its byte completed
// one; the digest then appears one word per cycle while m_tready is high.
// The round loop, prepared a + M + K plus f, rotate and add, sets the rate.
// A stalled receiver simply holds the current digest word; no new input is
// taken until all four words have been delivered.
// Reset loads the standard initial value and clears the byte and bit counts;
// the engine is ready right after reset is released.
module md5_hash_engine
#(
    parameter int LENGTH_COUNTER_BITS = md5_pkg::LENGTH_COUNTER_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_index
    output logic        m_tlast    // last_word
);

    md5_pkg::state_t state_reg, state_next;
    md5_pkg::pass_t  pass_reg, pass_next;

    logic                           last_pend_reg, last_pend_next;
    logic [5:0]                     cnt_reg, cnt_next;
    logic [LENGTH_COUNTER_BITS-1:0] len_reg, len_next;
    logic [5:0]                     round_reg, round_next;
    logic [1:0]                     word_idx_reg, word_idx_next;
    logic [31:0]                    chain_reg [4];
    logic [31:0]                    chain_next [4];
    logic [31:0]                    work_reg [4];
    logic [31:0]                    work_next [4];
    logic [31:0]                    pre_reg, pre_next;
    logic [31:0]                    buf_reg [16];
    logic [31:0]                    buf_next [16];

    logic        in_fire;
    logic        out_fire;
    logic [63:0] len_field;

    md5_pkg::round_ctrl_t rctl;
    logic [31:0]          pre_base;
    logic [31:0]          b_new;
    logic [31:0]          pre_sum_new;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign len_field = 64'(len_reg);

    // The next round's sum uses the current d, which becomes its a.
    always_comb
    begin
        if (state_reg == md5_pkg::ST_SETUP)
        begin
            rctl.round     = '0;
            rctl.pre_round = '0;
            pre_base       = chain_reg[0];
        end
        else
        begin
            rctl.round     = round_reg;
            rctl.pre_round = round_reg + 6'd1;
            pre_base       = work_reg[3];
        end
    end

    md5_round u_round
    (
        .ctrl        (rctl),
        .pre_sum     (pre_reg),
        .b           (work_reg[1]),
        .c           (work_reg[2]),
        .d           (work_reg[3]),
        .pre_base    (pre_base),
        .pre_word    (buf_reg[md5_pkg::md5_msg_index(rctl.pre_round)]),
        .b_new       (b_new),
        .pre_sum_new (pre_sum_new)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser[0] && (cnt_reg == md5_pkg::LAST_BYTE_POS))
                        state_next = md5_pkg::ST_SETUP;
                    else if (s_tlast)
                        state_next = md5_pkg::ST_PAD;
                end
            end
            md5_pkg::ST_PAD:   state_next = md5_pkg::ST_SETUP;
            md5_pkg::ST_SETUP: state_next = md5_pkg::ST_ROUND;
            md5_pkg::ST_ROUND:
            begin
                if (round_reg == md5_pkg::LAST_ROUND)
                    state_next = md5_pkg::ST_FINAL;
            end
            md5_pkg::ST_FINAL:
            begin
                unique case (pass_reg)
                    md5_pkg::PASS_DATA:
                        state_next = last_pend_reg ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
                    md5_pkg::PASS_SPILL: state_next = md5_pkg::ST_SETUP;
                    default:             state_next = md5_pkg::ST_OUT;
                endcase
            end
            md5_pkg::ST_OUT:
            begin
                if (out_fire && (word_idx_reg == md5_pkg::LAST_WORD_IDX))
                    state_next = md5_pkg::ST_IDLE;
            end
            default: state_next = md5_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_tready = (state_reg == md5_pkg::ST_IDLE);
        m_tvalid = (state_reg == md5_pkg::ST_OUT);
        m_tdata  = chain_reg[word_idx_reg];
        m_tuser  = word_idx_reg;
        m_tlast  = (word_idx_reg == md5_pkg::LAST_WORD_IDX);
    end

    // Datapath and counters.
    always_comb
    begin
        pass_next      = pass_reg;
        last_pend_next = last_pend_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        round_next     = round_reg;
        word_idx_next  = word_idx_reg;
        pre_next       = pre_reg;
        for (int i = 0; i < 4; i++)
        begin
            chain_next[i] = chain_reg[i];
            work_next[i]  = work_reg[i];
        end
        for (int w = 0; w < 16; w++)
            buf_next[w] = buf_reg[w];

        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (in_fire && s_tuser[0])
                begin
                    buf_next[cnt_reg[5:2]][{cnt_reg[1:0], 3'b000} +: 8] = s_tdata;
                    cnt_next       = cnt_reg + 6'd1;
                    len_next       = len_reg + LENGTH_COUNTER_BITS'(8);
                    pass_next      = md5_pkg::PASS_DATA;
                    last_pend_next = s_tlast;
                end
            end
            md5_pkg::ST_PAD:
            begin
                // The pad byte goes at the fill position, zeros after it.
                for (int w = 0; w < 16; w++)
                begin
                    for (int bt = 0; bt < 4; bt++)
                    begin
                        if (6'(w * 4 + bt) == cnt_reg)
                            buf_next[w][bt*8 +: 8] = md5_pkg::PAD_BYTE;
                        else if (6'(w * 4 + bt) > cnt_reg)
                            buf_next[w][bt*8 +: 8] = 8'h00;
                    end
                end
                if (cnt_reg >= md5_pkg::LEN_FIELD_POS)
                begin
                    pass_next = md5_pkg::PASS_SPILL;
                end
                else
                begin
                    pass_next    = md5_pkg::PASS_LAST;
                    buf_next[14] = len_field[31:0];
                    buf_next[15] = len_field[63:32];
                end
            end
            md5_pkg::ST_SETUP:
            begin
                for (int i = 0; i < 4; i++)
                    work_next[i] = chain_reg[i];
                pre_next   = pre_sum_new;
                round_next = '0;
            end
            md5_pkg::ST_ROUND:
            begin
                work_next[0] = work_reg[3];
                work_next[1] = b_new;
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                pre_next     = pre_sum_new;
                round_next   = round_reg + 6'd1;
            end
            md5_pkg::ST_FINAL:
            begin
                for (int i = 0; i < 4; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                if (pass_reg == md5_pkg::PASS_SPILL)
                begin
                    // Second padding block: zeros and the length field.
                    for (int w = 0; w < 14; w++)
                        buf_next[w] = '0;
                    buf_next[14] = len_field[31:0];
                    buf_next[15] = len_field[63:32];
                    pass_next    = md5_pkg::PASS_LAST;
                end
            end
            md5_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    word_idx_next = word_idx_reg + 2'd1;
                    if (word_idx_reg == md5_pkg::LAST_WORD_IDX)
                    begin
                        chain_next[0]  = md5_pkg::IV_A;
                        chain_next[1]  = md5_pkg::IV_B;
                        chain_next[2]  = md5_pkg::IV_C;
                        chain_next[3]  = md5_pkg::IV_D;
                        cnt_next       = '0;
                        len_next       = '0;
                        last_pend_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_IDLE;
            pass_reg      <= md5_pkg::PASS_DATA;
            last_pend_reg <= 1'b0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            round_reg     <= '0;
            word_idx_reg  <= '0;
            chain_reg[0]  <= md5_pkg::IV_A;
            chain_reg[1]  <= md5_pkg::IV_B;
            chain_reg[2]  <= md5_pkg::IV_C;
            chain_reg[3]  <= md5_pkg::IV_D;
            for (int i = 0; i < 4; i++)
                work_reg[i] <= '0;
            pre_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            last_pend_reg <= last_pend_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            round_reg     <= round_next;
            word_idx_reg  <= word_idx_next;
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= chain_next[i];
                work_reg[i]  <= work_next[i];
            end
            pre_reg       <= pre_next;
        end
    end

    // The block buffer holds block data only and needs no reset.
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < 16; w++)
            buf_reg[w] <= buf_next[w];
    end

endmodule

/* rtl/core/md5_checker.sv */
module md5_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [0:0]  s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled digest word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("digest word changed while stalled");

    // Input is never taken while the digest is being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready during digest output");

    // The last flag sits on the fourth word only.
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
        else $error("last flag does not match word index");

    // Ending a message always starts padding or compression work.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("ready right after a last transaction");

    // Digest words follow one another in order.
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tuser == 2'($past(m_tuser) + 2'd1)))
        else $error("digest words out of order");

endmodule

bind md5_hash_engine md5_checker u_md5_checker (.*);

/* bench/tb_md5_hash_engine.sv */
module tb_md5_hash_engine;

    timeunit 1ns;
    timeprecision 1ps;

    // One digest word as it should leave the master channel.
    typedef struct {
        logic [31:0] word;
        logic [1:0]  index;
        logic        tail;
    } digest_word_t;

    typedef logic [7:0] message_q_t[$];

    // Scoreboard: a software MD5 engine that follows every accepted input
    // transaction and keeps the digest words it owes the receiver.
    class md5_digest_model;
        bit [31:0]    round_k[64];
        int unsigned  rot_k[16];
        bit [31:0]    chain[4];
        bit [31:0]    block_words[16];
        bit [5:0]     fill;
        bit [63:0]    bit_count;
        digest_word_t owed[$];
        int unsigned  errors;
        int unsigned  words_checked;

        function new();
            round_k = '{
                32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
            };
            rot_k = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            errors = 0;
            words_checked = 0;
            restart();
        endfunction

        function void restart();
            chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
            fill = '0;
            bit_count = '0;
        endfunction

        function void put_byte(int unsigned pos, bit [7:0] value);
            block_words[pos / 4][8 * (pos % 4) +: 8] = value;
        endfunction

        function void compress();
            bit [31:0]   a;
            bit [31:0]   b;
            bit [31:0]   c;
            bit [31:0]   d;
            bit [31:0]   f;
            bit [31:0]   t;
            int unsigned g;
            int unsigned s;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int unsigned r = 0; r < 64; r++)
            begin
                case (r / 16)
                    0: begin f = d ^ (b & (c ^ d)); g = r;                end
                    1: begin f = c ^ (d & (b ^ c)); g = (5 * r + 1) % 16; end
                    2: begin f = b ^ c ^ d;         g = (3 * r + 5) % 16; end
                    default: begin f = c ^ (b | ~d); g = (7 * r) % 16;   end
                endcase
                s = rot_k[(r / 16) * 4 + r % 4];
                t = a + f + block_words[g] + round_k[r];
                t = (t << s) | (t >> (32 - s));
                a = d;
                d = c;
                c = b;
                b = b + t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        // Follows one accepted input transaction; a last one queues four words.
        function void note_input(bit [7:0] data, bit has_byte, bit is_last);
            int unsigned  pos;
            digest_word_t w;
            if (has_byte)
            begin
                put_byte(fill, data);
                bit_count += 64'd8;
                fill++;
                if (fill == 0)
                    compress();
            end
            if (!is_last)
                return;
            pos = fill;
            put_byte(pos, 8'h80);
            for (int unsigned i = pos + 1; i < 64; i++)
                put_byte(i, 8'h00);
            // No room for the length field: it goes into a block of its own.
            if (pos >= 56)
            begin
                compress();
                foreach (block_words[i])
                    block_words[i] = '0;
            end
            block_words[14] = bit_count[31:0];
            block_words[15] = bit_count[63:32];
            compress();
            for (int i = 0; i < 4; i++)
            begin
                w.word = chain[i];
                w.index = i[1:0];
                w.tail = (i == 3);
                owed.push_back(w);
            end
            restart();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [31:0] word, logic [1:0] index, logic tail);
            digest_word_t w;
            words_checked++;
            if (owed.size() == 0)
            begin
                report($sformatf("digest word %h arrived with nothing outstanding", word));
                return;
            end
            w = owed.pop_front();
            if (word !== w.word)
                report($sformatf("word %0d: digest %h, predicted %h", w.index, word, w.word));
            if (index !== w.index)
                report($sformatf("word index %0d, predicted %0d", index, w.index));
            if (tail !== w.tail)
                report($sformatf("word %0d: last flag %b, predicted %b", w.index, tail, w.tail));
        endtask

        function int pending();
            return owed.size();
        endfunction
    endclass

    // Every input of the engine holds a known value from time zero.
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    md5_digest_model sb = new();

    // While steady is set, neither side of the bench inserts any gap.
    bit          steady = 1'b0;
    int unsigned msg_count = 0;
    int unsigned byte_count = 0;
    int unsigned item_count = 0;

    md5_hash_engine dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // The receiver drops tready at random, about six percent of the time unless
    // steady is set. It changes only on the falling edge so the engine sees a
    // stable value at the rising edge.
    always @(negedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 6);

    // Digest words are sampled at the rising edge, before the engine's own
    // register updates for that edge take effect.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);

    // Presents one input transaction and waits for the handshake. The task is
    // entered and left at a falling edge, so tvalid is assigned once per step
    // and stays high across back-to-back transactions.
    task automatic send_item(input logic [7:0] data, input logic has_byte,
                             input logic is_last);
        while (!steady && $urandom_range(0, 99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= has_byte;
        s_tlast <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(data, has_byte, is_last);
        if (has_byte || is_last)
            item_count++;
        if (has_byte)
            byte_count++;
        @(negedge clk);
    endtask

    // Sends a whole message. With byte_on_last the final byte rides on the
    // transaction that ends the message; otherwise an empty final transaction
    // follows the bytes. Now and then a transaction without a byte is slipped
    // in, which the engine must ignore.
    task automatic send_message(input message_q_t bytes, input bit byte_on_last);
        bit tail;
        foreach (bytes[i])
        begin
            if ($urandom_range(0, 99) < 8)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            tail = byte_on_last && (i == bytes.size() - 1);
            send_item(bytes[i], 1'b1, tail);
        end
        if (!byte_on_last || bytes.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        msg_count++;
    endtask

    initial
    begin
        message_q_t  msg;
        int unsigned len;
        int unsigned k;
        int          n;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed messages. The empty message comes first, closed by a final
        // transaction that carries no byte.
        msg = {};
        send_message(msg, 1'b0);
        // A single byte on the transaction that ends the message.
        msg = {8'h61};
        send_message(msg, 1'b1);
        // Both extreme byte values, then an empty final transaction.
        msg = {8'h00, 8'hff};
        send_message(msg, 1'b0);
        // A stray transaction with no byte between two messages.
        send_item(8'h5a, 1'b0, 1'b0);
        msg = {8'h61, 8'h62, 8'h63};
        send_message(msg, 1'b1);
        msg = {8'h80, 8'h7f, 8'h01, 8'hfe};
        send_message(msg, 1'b0);

        // Random messages. The first fills exactly one block, so its padding
        // lands at the start of a fresh block; the second leaves too little
        // room for the length field, which spills into a second block. The
        // second one runs as a long stretch with no gaps on either side.
        for (k = 0; k < 2; k++)
        begin
            len = (k == 0) ? 64 : $urandom_range(56, 60);
            steady = (k == 1);
            msg = {};
            repeat (len)
                msg.push_back(8'($urandom_range(0, 255)));
            send_message(msg, 1'($urandom_range(0, 1)));
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Drain the outstanding digest words, then watch a while longer so a
        // spurious extra word would still be caught.
        for (n = 0; sb.pending() > 0 && n < 20000; n++)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d digest words never arrived", sb.pending()));

        $display("Run covered %0d messages holding %0d bytes, with block-boundary and spill padding.",
                 msg_count, byte_count);
        $display("%0d digest words were compared with the predicted chaining values.",
                 sb.words_checked);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* md5_hash_engine.f */
rtl/core/md5_pkg.sv
rtl/core/md5_round.sv
rtl/core/md5_hash_engine.sv
rtl/core/md5_checker.sv
bench/tb_md5_hash_engine.sv
